FILE: src/dpat_pkg.sv
// Shared types and constants for the demand-paged address translator.
// Used by every module in src; depends on nothing else.
`timescale 1ns / 1ps

package dpat_pkg;

  // Geometry
  localparam int FRAME_BYTES = 256;
  localparam int FRAME_COUNT = 256;
  localparam int PAGE_COUNT  = 256;

  localparam int ADDR_W   = 16;
  localparam int PADDR_W  = 16;
  localparam int REQ_W    = 8;
  localparam int BYTE_W   = 8;
  localparam int FAULT_W  = 16;
  localparam int XLAT_W   = 32;
  localparam int STATUS_W = 3;

  localparam int OFFSET_W  = $clog2(FRAME_BYTES);
  localparam int FRAME_W   = $clog2(FRAME_COUNT);
  localparam int PAGE_W    = $clog2(PAGE_COUNT);
  localparam int NFF_W     = $clog2(FRAME_COUNT + 1);
  localparam int MEM_AW    = FRAME_W + OFFSET_W;
  localparam int MEM_WORDS = FRAME_COUNT * FRAME_BYTES;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef logic [OFFSET_W-1:0] offset_t;
  typedef logic [FRAME_W-1:0]  frame_t;
  typedef logic [PAGE_W-1:0]   page_t;
  typedef logic [BYTE_W-1:0]   byte_t;

  typedef enum logic [0:0] {
    OP_XLATE = 1'b0,
    OP_FILL  = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT     = 3'd0,
    ST_DONE    = 3'd1,
    ST_REQ     = 3'd2,
    ST_NOFRAME = 3'd3,
    ST_SEQ     = 3'd4
  } status_t;

  // One classified beat handed from front to back
  typedef struct packed {
    logic                emit;       // produces a result beat
    logic                we;         // writes one fill byte
    logic                rd;         // result carries address and data
    status_t             status;
    frame_t              frame;      // read location
    offset_t             offset;
    frame_t              wframe;     // write location
    offset_t             woffset;
    byte_t               wdata;
    logic [REQ_W-1:0]    req_page;
    logic [FAULT_W-1:0]  fault_total;
    logic [XLAT_W-1:0]   xlat_total;
  } cmd_t;

endpackage

FILE: src/demand_paged_address_translator.sv
// Demand-paged address translator, top level.
// Ties dpat_front, dpat_queue and dpat_back together; uses dpat_pkg.
//
// Input channel (in_valid/in_stall): opcode 0 translates vaddr,
// opcode 1 supplies the next fill byte of the requested page.
// Output channel (out_valid/out_stall): one result beat per translate, one
// after the last fill byte of a page and one per fill byte with no page
// requested; other fill bytes give no beat.
// Throughput: one input beat per cycle while the command queue is not full,
// set by the single page-table read port in the front end and the single
// write and read ports of the frame memory in the back end. A page fault
// therefore costs its request beat plus FRAME_BYTES fill beats.
// A result passes through the item register, the command queue and the
// result register, in that order, before it is valid.
// When the receiver stalls, the result register holds; the command queue
// keeps taking beats until it fills, then in_stall rises.
// Reset clears the page valid bits, frame allocation, fill state and the
// totals at once; no clearing pass is needed. Frame memory and the page
// frame table hold no defined content until written.
`timescale 1ns / 1ps

module demand_paged_address_translator import dpat_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 opcode,
  input  logic [ADDR_W-1:0]    vaddr,
  input  logic signed [7:0]    fill_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  status,
  output logic [PADDR_W-1:0]   physical_addr,
  output logic signed [7:0]    data_value,
  output logic [REQ_W-1:0]     request_page,
  output logic [FAULT_W-1:0]   fault_total,
  output logic [XLAT_W-1:0]    translated_total
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic pop;
  logic nonempty;
  cmd_t head;

  dpat_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .vaddr        (vaddr),
    .fill_byte    (fill_byte),
    .push         (push),
    .push_cmd     (push_cmd),
    .q_full       (q_full)
  );

  dpat_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .nonempty (nonempty),
    .head     (head)
  );

  dpat_back u_back (
    .clk              (clk),
    .rst              (rst),
    .nonempty         (nonempty),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .physical_addr    (physical_addr),
    .data_value       (data_value),
    .request_page     (request_page),
    .fault_total      (fault_total),
    .translated_total (translated_total)
  );

endmodule

FILE: src/dpat_front.sv
// Front end: accepts beats, looks up the page table and classifies each beat.
// Holds the page table, fill sequencing and the running totals; uses dpat_pkg.
`timescale 1ns / 1ps

module dpat_front import dpat_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                opcode,
  input  logic [ADDR_W-1:0]   vaddr,
  input  logic signed [7:0]   fill_byte,
  output logic                push,
  output cmd_t                push_cmd,
  input  logic                q_full
);

  // Item register and table read data
  logic              st_valid;
  opcode_t           st_op;
  logic [ADDR_W-1:0] st_addr;
  byte_t             st_fill;
  frame_t            tbl_rd;

  // Page table
  logic [PAGE_COUNT-1:0] page_valid;
  frame_t                page_frame [PAGE_COUNT];

  // Translator state
  logic [NFF_W-1:0]   next_free_frame, next_free_frame_next;
  logic [FAULT_W-1:0] fault_count, fault_count_next;
  logic [XLAT_W-1:0]  translation_count, translation_count_next;
  logic               filling, filling_next;
  offset_t            fill_pos, fill_pos_next;
  offset_t            pending_offset, pending_offset_next;
  frame_t             pending_frame, pending_frame_next;

  logic    advance;
  logic    in_acc;
  logic    map_we;
  page_t   st_page;
  offset_t st_off;
  page_t   in_page;

  assign advance  = st_valid && !q_full;
  assign in_stall = st_valid && q_full;
  assign in_acc   = in_valid && !in_stall;
  assign push     = advance;
  assign st_page  = st_addr[OFFSET_W +: PAGE_W];
  assign st_off   = st_addr[OFFSET_W-1:0];
  assign in_page  = vaddr[OFFSET_W +: PAGE_W];

  // Load the item register
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (in_acc) begin
      st_valid <= 1'b1;
    end else if (advance) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      st_op   <= opcode_t'(opcode);
      st_addr <= vaddr;
      st_fill <= byte_t'(fill_byte);
    end
  end

  // Page table: write on map, read at accept; forward a same-cycle map
  always_ff @(posedge clk) begin
    if (advance && map_we) begin
      page_frame[st_page] <= pending_frame_next;
    end
    if (in_acc) begin
      if (advance && map_we && (st_page == in_page)) begin
        tbl_rd <= pending_frame_next;
      end else begin
        tbl_rd <= page_frame[in_page];
      end
    end
  end

  // Classify the held beat and work out the next state
  always_comb begin
    push_cmd               = '0;
    push_cmd.status        = ST_SEQ;
    push_cmd.fault_total   = fault_count;
    push_cmd.xlat_total    = translation_count;
    map_we                 = 1'b0;
    next_free_frame_next   = next_free_frame;
    fault_count_next       = fault_count;
    translation_count_next = translation_count;
    filling_next           = filling;
    fill_pos_next          = fill_pos;
    pending_offset_next    = pending_offset;
    pending_frame_next     = pending_frame;

    unique case (st_op)
      OP_XLATE: begin
        push_cmd.emit = 1'b1;
        if (filling) begin
          push_cmd.status = ST_SEQ;
        end else if (page_valid[st_page]) begin
          if (translation_count != '1) begin
            translation_count_next = translation_count + 1'b1;
          end
          push_cmd.status     = ST_HIT;
          push_cmd.rd         = 1'b1;
          push_cmd.frame      = tbl_rd;
          push_cmd.offset     = st_off;
          push_cmd.xlat_total = translation_count_next;
        end else if (next_free_frame >= NFF_W'(FRAME_COUNT)) begin
          push_cmd.status = ST_NOFRAME;
        end else begin
          if (fault_count != '1) begin
            fault_count_next = fault_count + 1'b1;
          end
          map_we               = 1'b1;
          pending_frame_next   = next_free_frame[FRAME_W-1:0];
          next_free_frame_next = next_free_frame + 1'b1;
          pending_offset_next  = st_off;
          fill_pos_next        = '0;
          filling_next         = 1'b1;
          push_cmd.status      = ST_REQ;
          push_cmd.req_page    = REQ_W'(st_page);
          push_cmd.fault_total = fault_count_next;
        end
      end
      OP_FILL: begin
        if (!filling) begin
          push_cmd.emit   = 1'b1;
          push_cmd.status = ST_SEQ;
        end else begin
          push_cmd.we      = 1'b1;
          push_cmd.wframe  = pending_frame;
          push_cmd.woffset = fill_pos;
          push_cmd.wdata   = st_fill;
          fill_pos_next    = fill_pos + 1'b1;
          if (fill_pos == OFFSET_W'(FRAME_BYTES - 1)) begin
            if (translation_count != '1) begin
              translation_count_next = translation_count + 1'b1;
            end
            filling_next        = 1'b0;
            fill_pos_next       = '0;
            push_cmd.emit       = 1'b1;
            push_cmd.rd         = 1'b1;
            push_cmd.status     = ST_DONE;
            push_cmd.frame      = pending_frame;
            push_cmd.offset     = pending_offset;
            push_cmd.xlat_total = translation_count_next;
          end
        end
      end
      default: begin
        push_cmd.emit = 1'b1;
      end
    endcase
  end

  // Commit state as the beat leaves for the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      page_valid        <= '0;
      next_free_frame   <= '0;
      fault_count       <= '0;
      translation_count <= '0;
      filling           <= 1'b0;
      fill_pos          <= '0;
      pending_offset    <= '0;
      pending_frame     <= '0;
    end else if (advance) begin
      if (map_we) begin
        page_valid[st_page] <= 1'b1;
      end
      next_free_frame   <= next_free_frame_next;
      fault_count       <= fault_count_next;
      translation_count <= translation_count_next;
      filling           <= filling_next;
      fill_pos          <= fill_pos_next;
      pending_offset    <= pending_offset_next;
      pending_frame     <= pending_frame_next;
    end
  end

`ifndef SYNTHESIS
  a_fill_has_frame: assert property (@(posedge clk) disable iff (rst)
    filling |-> (next_free_frame != '0))
    else $error("filling without an allocated frame");

  a_fill_pos_idle: assert property (@(posedge clk) disable iff (rst)
    (fill_pos != '0) |-> filling)
    else $error("fill position moved outside a fill");

  a_req_starts_fill: assert property (@(posedge clk) disable iff (rst)
    (push && push_cmd.emit && (push_cmd.status == ST_REQ)) |=> filling)
    else $error("page request did not start a fill");
`endif

endmodule

FILE: src/dpat_queue.sv
// Short command queue between the front end and the back end.
// Register-based FIFO of cmd_t entries; uses dpat_pkg.
`timescale 1ns / 1ps

module dpat_queue import dpat_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output cmd_t head
);

  cmd_t              entry [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign nonempty = (count != '0);
  assign head     = entry[rd_ptr];

  // Store the pushed beat
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> nonempty)
    else $error("pop from an empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue occupancy out of range");
`endif

endmodule

FILE: src/dpat_back.sv
// Back end: carries out fill writes and frame reads, drives the result register.
// Holds the frame memory; uses dpat_pkg.
`timescale 1ns / 1ps

module dpat_back import dpat_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     nonempty,
  input  cmd_t                     head,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STATUS_W-1:0]      status,
  output logic [PADDR_W-1:0]       physical_addr,
  output logic signed [7:0]        data_value,
  output logic [REQ_W-1:0]         request_page,
  output logic [FAULT_W-1:0]       fault_total,
  output logic [XLAT_W-1:0]        translated_total
);

  byte_t mem [MEM_WORDS];

  logic              load_ok;
  logic              load;
  logic [MEM_AW-1:0] waddr;
  logic [MEM_AW-1:0] raddr;

  status_t            status_r;
  logic [PADDR_W-1:0] paddr_r;
  byte_t              data_r;
  logic [REQ_W-1:0]   req_r;
  logic [FAULT_W-1:0] fault_r;
  logic [XLAT_W-1:0]  xlat_r;

  assign load_ok = !out_valid || !out_stall;
  assign pop     = nonempty && (!head.emit || load_ok);
  assign load    = pop && head.emit;
  assign waddr   = {head.wframe, head.woffset};
  assign raddr   = {head.frame, head.offset};

  // Frame memory: one write and one read a cycle, forward same-address write
  always_ff @(posedge clk) begin
    if (pop && head.we) begin
      mem[waddr] <= head.wdata;
    end
    if (load) begin
      if (!head.rd) begin
        data_r <= '0;
      end else if (head.we && (waddr == raddr)) begin
        data_r <= head.wdata;
      end else begin
        data_r <= mem[raddr];
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= head.status;
      paddr_r  <= head.rd ? PADDR_W'(raddr) : '0;
      req_r    <= head.req_page;
      fault_r  <= head.fault_total;
      xlat_r   <= head.xlat_total;
    end
  end

  // Result valid: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (load_ok) begin
      out_valid <= 1'b0;
    end
  end

  assign status           = status_r;
  assign physical_addr    = paddr_r;
  assign data_value       = data_r;
  assign request_page     = req_r;
  assign fault_total      = fault_r;
  assign translated_total = xlat_r;

endmodule

FILE: tb/demand_paged_address_translator_tb.sv
// Self-checking testbench for demand_paged_address_translator.
// Predicts page faults, fills and hits in its own model and checks each result beat.
// Depends on dpat_pkg and the block under src.
`timescale 1ns / 1ps

module demand_paged_address_translator_tb;
  import dpat_pkg::*;

  localparam int     RESULT_LATENCY = 3;
  localparam int     SETTLE_CYCLES  = RESULT_LATENCY + 4;
  localparam int     LONG_GAP       = 24;
  // Directed tests plus random traffic stay under about 2000 beats;
  // each beat may wait out a long sender gap and a long receiver stall.
  localparam longint CYCLE_LIMIT    = 64'd4 * 64'd2000 * (2 * LONG_GAP + 8);
  localparam int     PRINT_CAP      = 200;

  typedef struct {
    status_t              status;
    logic [PADDR_W-1:0]   paddr;
    byte_t                data;
    logic [REQ_W-1:0]     page;
    logic [FAULT_W-1:0]   faults;
    logic [XLAT_W-1:0]    xlats;
  } xlat_result_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic                opcode;
  logic [ADDR_W-1:0]   vaddr;
  logic signed [7:0]   fill_byte;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] status;
  logic [PADDR_W-1:0]  physical_addr;
  logic signed [7:0]   data_value;
  logic [REQ_W-1:0]    request_page;
  logic [FAULT_W-1:0]  fault_total;
  logic [XLAT_W-1:0]   translated_total;

  // Translator model state
  bit                  pg_valid [PAGE_COUNT];
  frame_t              pg_frame [PAGE_COUNT];
  byte_t               frame_mem [MEM_WORDS];
  logic [NFF_W-1:0]    next_frame;
  logic [FAULT_W-1:0]  fault_cnt;
  logic [XLAT_W-1:0]   xlat_cnt;
  bit                  fill_active;
  logic [OFFSET_W:0]   fill_pos;
  offset_t             pend_off;
  frame_t              pend_frame;
  page_t               mapped_pages [$];

  xlat_result_t        outcomes_due [$];
  xlat_result_t        head;
  int                  mismatches;
  int                  beats_sent;
  longint              cycle_count;
  bit                  send_idle;
  bit                  recv_idle;

  demand_paged_address_translator u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .opcode           (opcode),
    .vaddr            (vaddr),
    .fill_byte        (fill_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .physical_addr    (physical_addr),
    .data_value       (data_value),
    .request_page     (request_page),
    .fault_total      (fault_total),
    .translated_total (translated_total)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly short idle spans, now and then a long one
  function automatic int idle_span();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, LONG_GAP);
    return $urandom_range(1, 3);
  endfunction

  task automatic reroll_idling();
    send_idle = ($urandom_range(0, 3) != 0);
    recv_idle = ($urandom_range(0, 3) != 0);
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("%0t ns: mismatch, %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Queue one expected result beat from the current model state
  task automatic push_outcome(input status_t st, input int frame, input int offset,
                              input bit with_data, input int page);
    xlat_result_t r;
    r.status = st;
    r.paddr  = '0;
    r.data   = '0;
    if (with_data) begin
      r.paddr = PADDR_W'(frame * FRAME_BYTES + offset);
      r.data  = frame_mem[(frame % FRAME_COUNT) * FRAME_BYTES + offset % FRAME_BYTES];
    end
    r.page   = REQ_W'(page);
    r.faults = fault_cnt;
    r.xlats  = xlat_cnt;
    outcomes_due.push_back(r);
  endtask

  // Advance the translator model by one accepted beat
  task automatic track_translation(input opcode_t op, input logic [ADDR_W-1:0] addr,
                                   input byte_t fb);
    int page;
    int offset;
    page   = (int'(addr) / FRAME_BYTES) % PAGE_COUNT;
    offset = int'(addr) % FRAME_BYTES;
    if (op == OP_XLATE) begin
      if (fill_active) begin
        push_outcome(ST_SEQ, 0, 0, 1'b0, 0);
      end else if (pg_valid[page]) begin
        if (xlat_cnt != {XLAT_W{1'b1}}) xlat_cnt++;
        push_outcome(ST_HIT, int'(pg_frame[page]), offset, 1'b1, 0);
      end else if (next_frame >= FRAME_COUNT) begin
        push_outcome(ST_NOFRAME, 0, 0, 1'b0, 0);
      end else begin
        if (fault_cnt != {FAULT_W{1'b1}}) fault_cnt++;
        pend_frame     = frame_t'(next_frame);
        next_frame     = next_frame + 1'b1;
        pg_valid[page] = 1'b1;
        pg_frame[page] = pend_frame;
        pend_off       = offset_t'(offset);
        fill_pos       = '0;
        fill_active    = 1'b1;
        mapped_pages.push_back(page_t'(page));
        push_outcome(ST_REQ, 0, 0, 1'b0, page);
      end
    end else if (!fill_active) begin
      push_outcome(ST_SEQ, 0, 0, 1'b0, 0);
    end else begin
      // Store the byte; only the last one of the page yields a beat
      frame_mem[int'(pend_frame) * FRAME_BYTES + int'(fill_pos)] = fb;
      fill_pos = fill_pos + 1'b1;
      if (fill_pos == FRAME_BYTES) begin
        fill_active = 1'b0;
        fill_pos    = '0;
        if (xlat_cnt != {XLAT_W{1'b1}}) xlat_cnt++;
        push_outcome(ST_DONE, int'(pend_frame), int'(pend_off), 1'b1, 0);
      end
    end
  endtask

  // Drive one input beat and hold it until accepted
  task automatic send_beat(input opcode_t op, input logic [ADDR_W-1:0] addr,
                           input byte_t fb);
    int gap;
    gap = (send_idle && $urandom_range(0, 2) == 0) ? idle_span() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    vaddr     <= addr;
    fill_byte <= fb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_translation(op, addr, fb);
    beats_sent++;
  endtask

  // Supply a full page of fill bytes, optionally with stray translates mixed in
  task automatic supply_page(input bit extremes, input int noise_pct);
    byte_t b;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      if (noise_pct > 0 && $urandom_range(0, 99) < noise_pct)
        send_beat(OP_XLATE, ADDR_W'($urandom), BYTE_W'($urandom));
      b = BYTE_W'($urandom);
      if (extremes && i == 0) b = 8'h80;
      if (extremes && i == FRAME_BYTES - 1) b = 8'h7F;
      send_beat(OP_FILL, ADDR_W'($urandom), b);
    end
  endtask

  task automatic touch_address(input logic [ADDR_W-1:0] addr, input int noise_pct);
    send_beat(OP_XLATE, addr, BYTE_W'($urandom));
    if (fill_active) supply_page(1'b0, noise_pct);
  endtask

  function automatic logic [ADDR_W-1:0] mapped_address();
    page_t p;
    p = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
    return ADDR_W'(int'(p) * FRAME_BYTES + $urandom_range(0, FRAME_BYTES - 1));
  endfunction

  // Hold the sender until every due result has come back
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Fill bytes with no page requested are out of sequence
  task automatic test_sequence_errors();
    send_beat(OP_FILL, 16'hFFFF, 8'h80);
    send_beat(OP_FILL, 16'h0000, 8'h7F);
    send_beat(OP_FILL, 16'h5A5A, 8'hFF);
    send_beat(OP_FILL, 16'hA5A5, 8'h00);
  endtask

  // Fault the top and bottom pages, with a translate landing mid-fill
  task automatic test_fault_fill();
    send_beat(OP_XLATE, 16'hFFFF, 8'h00);
    send_beat(OP_XLATE, 16'h0000, 8'h7F);
    supply_page(1'b1, 0);
    send_beat(OP_XLATE, 16'h00FF, 8'h80);
    supply_page(1'b1, 0);
    send_beat(OP_FILL, 16'h1234, 8'h55);
  endtask

  // Hits at the edges of both mapped pages and one inside page FF
  task automatic test_hits();
    send_beat(OP_XLATE, 16'hFF00, 8'h00);
    send_beat(OP_XLATE, 16'hFFFF, 8'h00);
    send_beat(OP_XLATE, 16'h0000, 8'h00);
    send_beat(OP_XLATE, 16'h00FF, 8'h00);
    send_beat(OP_XLATE, 16'hFF7F, 8'h00);
  endtask

  // Mostly hits on mapped pages, some new pages and some stray fills
  task automatic test_random_traffic(input int beats);
    int stop_at;
    int pick;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) begin
      if ($urandom_range(0, 63) == 0) reroll_idling();
      pick = $urandom_range(0, 99);
      if (pick < 5) send_beat(OP_FILL, ADDR_W'($urandom), BYTE_W'($urandom));
      else if (pick < 9) touch_address(ADDR_W'($urandom), 2);
      else send_beat(OP_XLATE, mapped_address(), BYTE_W'($urandom));
    end
  endtask

  // Receiver stalls
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (recv_idle && !rst && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (idle_span()) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted result beat with the oldest due one
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (outcomes_due.size() == 0) begin
        report_mismatch($sformatf("result beat with status %0d and nothing due", status));
      end else begin
        head = outcomes_due.pop_front();
        check_field("status", 32'(status), 32'(head.status));
        check_field("physical_addr", 32'(physical_addr), 32'(head.paddr));
        check_field("data_value", 32'(unsigned'(data_value)), 32'(head.data));
        check_field("request_page", 32'(request_page), 32'(head.page));
        check_field("fault_total", 32'(fault_total), 32'(head.faults));
        check_field("translated_total", translated_total, head.xlats);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    opcode    <= OP_XLATE;
    vaddr     <= '0;
    fill_byte <= '0;
    for (int i = 0; i < PAGE_COUNT; i++) begin
      pg_valid[i] = 1'b0;
      pg_frame[i] = '0;
    end
    next_frame  = '0;
    fault_cnt   = '0;
    xlat_cnt    = '0;
    fill_active = 1'b0;
    fill_pos    = '0;
    pend_off    = '0;
    pend_frame  = '0;
    mismatches  = 0;
    beats_sent  = 0;
    cycle_count = 0;
    send_idle   = 1'b1;
    recv_idle   = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_sequence_errors();
    test_fault_fill();
    test_hits();
    hold_until_drained();
    test_random_traffic(450);
    hold_until_drained();

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
src/dpat_pkg.sv
src/dpat_front.sv
src/dpat_queue.sv
src/dpat_back.sv
src/demand_paged_address_translator.sv
tb/demand_paged_address_translator_tb.sv
